// ===== hdl/ppu_pkg.sv =====
// ----------------------------------------------------------------------------
// ppu_pkg
// Types, constants and helpers shared by the particle pool update block.
// ----------------------------------------------------------------------------
package ppu_pkg;

  localparam int unsigned PoolSizeDef = 64;
  localparam int unsigned StepW       = 20;
  localparam int unsigned CfgDataW    = 32;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned IntervalW   = 24;
  localparam int unsigned LifeCfgW    = 24;
  localparam int unsigned IndexOutW   = 6;
  localparam int unsigned ProdW       = 53;
  localparam int unsigned WideW       = 37;

  localparam logic [IntervalW-1:0] SpawnIntervalRst = 24'd6554;
  localparam logic [LifeCfgW-1:0]  StartLifeRst     = 24'd65536;
  localparam logic signed [31:0]   StartVelXRst     = 32'sd0;
  localparam logic signed [31:0]   StartVelYRst     = 32'sd65536;
  localparam logic signed [31:0]   StartVelZRst     = 32'sd0;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SPAWN_INTERVAL = 3'd0,
    REG_START_LIFETIME = 3'd1,
    REG_START_VEL_X    = 3'd2,
    REG_START_VEL_Y    = 3'd3,
    REG_START_VEL_Z    = 3'd4
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC,
    ST_DIV,
    ST_RD,
    ST_LIFE,
    ST_MX,
    ST_MY,
    ST_MZ,
    ST_WB
  } state_e;

  // one pool slot
  typedef struct packed {
    logic signed [31:0] life;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic               vis;
  } row_t;

  function automatic logic signed [31:0] sat32(logic signed [WideW-1:0] v);
    logic [WideW-32:0] top;
    top = v[WideW-1:31];
    if (top == '0 || top == '1) begin
      return v[31:0];
    end else if (v[WideW-1]) begin
      return 32'sh8000_0000;
    end else begin
      return 32'sh7FFF_FFFF;
    end
  endfunction

  // position plus product floored to Q16.16, saturated
  function automatic logic signed [31:0] move_axis(logic signed [31:0] pos,
                                                   logic signed [ProdW-1:0] prod);
    logic signed [ProdW-1:0] shr;
    logic signed [WideW-1:0] sum;
    shr = prod >>> 16;
    sum = WideW'(pos) + WideW'(shr);
    return sat32(sum);
  endfunction

endpackage

// ===== hdl/ppu_if.sv =====
// ----------------------------------------------------------------------------
// ppu_if
// Valid/ready channels carrying tick words in and slot result words out.
// ----------------------------------------------------------------------------
interface ppu_in_if
  import ppu_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [StepW-1:0] time_step;

  modport source (output valid, output time_step, input ready);
  modport sink   (input valid, input time_step, output ready);
endinterface

interface ppu_out_if
  import ppu_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [IndexOutW-1:0] particle_index;
  logic                 visible;
  logic signed [31:0]   pos_x;
  logic signed [31:0]   pos_y;
  logic signed [31:0]   pos_z;
  logic signed [31:0]   life_left;
  logic                 is_last;

  modport source (output valid, output particle_index, output visible, output pos_x,
                  output pos_y, output pos_z, output life_left, output is_last,
                  input ready);
  modport sink   (input valid, input particle_index, input visible, input pos_x,
                  input pos_y, input pos_z, input life_left, input is_last,
                  output ready);
endinterface

// ===== hdl/particle_pool_update.sv =====
// ----------------------------------------------------------------------------
// particle_pool_update
// Advances a fixed particle pool by one time step per tick word and emits one
// result word per slot, in slot order.
//
//   channel   dir   handshake     payload
//   in_i      in    valid/ready   time_step
//   out_o     out   valid/ready   particle_index, visible, pos_x/y/z,
//                                 life_left, is_last
//   cfg       in    cfg_we_i      cfg_idx_i, cfg_data_i
//
// A tick first runs the serial divider of the spawn accounting (skipped when
// the interval is zero), then walks each slot through the life, X, Y, Z and
// write-back states, with the one multiplier shared by the three axes.
// Reset marks every pool row as unwritten, which reads as zero; no sweep.
// Results sit in an output register; the walk waits there while it is full.
// ----------------------------------------------------------------------------
module particle_pool_update
  import ppu_pkg::*;
#(
  parameter int unsigned POOL_SIZE = PoolSizeDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  ppu_in_if.sink              in_i,
  ppu_out_if.source           out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned IdxW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(POOL_SIZE - 1);

  // configuration
  logic [IntervalW-1:0] interval_q;
  logic [LifeCfgW-1:0]  start_life_q;
  logic signed [31:0]   start_vx_q;
  logic signed [31:0]   start_vy_q;
  logic signed [31:0]   start_vz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q   <= SpawnIntervalRst;
      start_life_q <= StartLifeRst;
      start_vx_q   <= StartVelXRst;
      start_vy_q   <= StartVelYRst;
      start_vz_q   <= StartVelZRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_SPAWN_INTERVAL: interval_q   <= cfg_data_i[IntervalW-1:0];
        REG_START_LIFETIME: start_life_q <= cfg_data_i[LifeCfgW-1:0];
        REG_START_VEL_X:    start_vx_q   <= cfg_data_i;
        REG_START_VEL_Y:    start_vy_q   <= cfg_data_i;
        REG_START_VEL_Z:    start_vz_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer
  state_e state_q, state_d;

  logic            out_valid_q;
  logic            out_free;
  logic            in_fire;
  logic            div_start;
  logic            div_done;
  logic [31:0]     div_quot;
  logic [IntervalW-1:0] div_rem;
  logic            rd_en;
  logic [IdxW-1:0] rd_addr;
  logic            wb_go;

  logic [StepW-1:0] step_q;
  logic [31:0]      timer_q;
  logic [15:0]      pend_q;
  logic [IdxW-1:0]  idx_q;
  logic             moving_q;
  row_t             row_q;
  row_t             rd_row;
  row_t             life_row;
  row_t             wb_row;
  logic signed [ProdW-1:0] prod_q;
  logic signed [ProdW-1:0] prod_c;
  logic signed [31:0]      mul_a;
  logic [32:0]             timer_sum;
  logic [31:0]             timer_sat;
  logic [32:0]             pend_sum;
  logic signed [31:0]      life_new;
  logic                    expired;

  assign out_free = !out_valid_q || out_o.ready;
  assign in_fire  = in_i.valid && in_i.ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_fire) state_d = ST_ACC;
      ST_ACC:   state_d = (interval_q == '0) ? ST_RD : ST_DIV;
      ST_DIV:   if (div_done) state_d = ST_RD;
      ST_RD:    state_d = ST_LIFE;
      ST_LIFE:  state_d = ST_MX;
      ST_MX:    state_d = ST_MY;
      ST_MY:    state_d = ST_MZ;
      ST_MZ:    state_d = ST_WB;
      ST_WB: begin
        if (out_free) state_d = (idx_q == LastIdx) ? ST_IDLE : ST_LIFE;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready = (state_q == ST_IDLE);
    div_start  = (state_q == ST_ACC) && (interval_q != '0);
    wb_go      = (state_q == ST_WB) && out_free;
    rd_en      = (state_q == ST_RD) || (wb_go && idx_q != LastIdx);
    rd_addr    = (state_q == ST_RD) ? idx_q : IdxW'(idx_q + 1'b1);
    unique case (state_q)
      ST_MX:   mul_a = row_q.vel_x;
      ST_MY:   mul_a = row_q.vel_y;
      default: mul_a = row_q.vel_z;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  ppu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (timer_sat),
    .divisor_i  (interval_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  ppu_mem #(
    .Depth (POOL_SIZE),
    .AddrW (IdxW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_row),
    .wr_en_i   (wb_go),
    .wr_addr_i (idx_q),
    .wr_data_i (wb_row)
  );

  // datapath
  assign timer_sum = {1'b0, timer_q} + 33'(step_q);
  assign timer_sat = timer_sum[32] ? 32'hFFFF_FFFF : timer_sum[31:0];
  assign pend_sum  = 33'(pend_q) + {1'b0, div_quot};
  assign life_new  = sat32(WideW'(rd_row.life) - $signed({17'b0, step_q}));
  assign expired   = life_new[31] || (life_new == '0);
  assign prod_c    = ProdW'(mul_a) * $signed({{(ProdW-StepW){1'b0}}, step_q});

  always_comb begin
    life_row      = rd_row;
    life_row.life = life_new;
    if (expired) begin
      if (pend_q != '0) begin
        life_row.life  = 32'(start_life_q);
        life_row.pos_x = '0;
        life_row.pos_y = '0;
        life_row.pos_z = '0;
        life_row.vel_x = start_vx_q;
        life_row.vel_y = start_vy_q;
        life_row.vel_z = start_vz_q;
        life_row.vis   = 1'b1;
      end else begin
        life_row.vis = 1'b0;
      end
    end
  end

  always_comb begin
    wb_row = row_q;
    if (moving_q) begin
      wb_row.pos_z = move_axis(row_q.pos_z, prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_q     <= '0;
      pend_q      <= '0;
      idx_q       <= '0;
      moving_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (wb_go) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_ACC: begin
          if (interval_q == '0) timer_q <= timer_sat;
          idx_q <= '0;
        end
        ST_DIV: begin
          if (div_done) begin
            timer_q <= 32'(div_rem);
            pend_q  <= (pend_sum > 33'd65535) ? 16'hFFFF : pend_sum[15:0];
          end
        end
        ST_LIFE: begin
          if (expired && pend_q != '0) begin
            pend_q   <= pend_q - 16'd1;
            moving_q <= 1'b1;
          end else begin
            moving_q <= !expired;
          end
        end
        ST_WB: begin
          if (out_free && idx_q != LastIdx) idx_q <= IdxW'(idx_q + 1'b1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) step_q <= in_i.time_step;
    unique case (state_q)
      ST_LIFE: row_q <= life_row;
      ST_MX:   prod_q <= prod_c;
      ST_MY: begin
        prod_q <= prod_c;
        if (moving_q) row_q.pos_x <= move_axis(row_q.pos_x, prod_q);
      end
      ST_MZ: begin
        prod_q <= prod_c;
        if (moving_q) row_q.pos_y <= move_axis(row_q.pos_y, prod_q);
      end
      ST_WB: begin
        if (out_free) begin
          out_o.particle_index <= IndexOutW'(idx_q);
          out_o.visible        <= wb_row.vis;
          out_o.pos_x          <= wb_row.pos_x;
          out_o.pos_y          <= wb_row.pos_y;
          out_o.pos_z          <= wb_row.pos_z;
          out_o.life_left      <= wb_row.life;
          out_o.is_last        <= (idx_q == LastIdx);
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid = out_valid_q;

endmodule

// ===== hdl/ppu_div.sv =====
// ----------------------------------------------------------------------------
// ppu_div
// Restoring divider, one quotient bit per cycle, for the spawn accounting.
// ----------------------------------------------------------------------------
module ppu_div
  import ppu_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [31:0]          dividend_i,
  input  logic [IntervalW-1:0] divisor_i,
  output logic                 done_o,
  output logic [31:0]          quot_o,
  output logic [IntervalW-1:0] rem_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [4:0]           cnt_q;
  logic [31:0]          quo_q;
  logic [IntervalW-1:0] rem_q;

  logic [IntervalW:0]   rem_sh;
  logic [IntervalW:0]   rem_sub;
  logic                 fits;

  assign rem_sh  = {rem_q, quo_q[31]};
  assign rem_sub = rem_sh - {1'b0, divisor_i};
  assign fits    = rem_sh >= {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[30:0], fits};
      rem_q <= fits ? rem_sub[IntervalW-1:0] : rem_sh[IntervalW-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

// ===== hdl/ppu_mem.sv =====
// ----------------------------------------------------------------------------
// ppu_mem
// Pool slot memory, one row per slot, with per-row valid bits so that an
// unwritten row reads as all zero after reset.
// ----------------------------------------------------------------------------
module ppu_mem
  import ppu_pkg::*;
#(
  parameter int unsigned Depth = PoolSizeDef,
  parameter int unsigned AddrW = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output row_t             rd_data_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  row_t             wr_data_i
);

  row_t             mem_q [Depth];
  logic [Depth-1:0] valid_q;
  row_t             rd_q;
  logic             rd_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_valid_q ? rd_q : '0;

endmodule
